// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// when ante holds, cons must hold at the same edge
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/xcr_pkg.sv =====
package xcr_pkg;

  localparam int PAYLOAD_BYTES = 128;
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

  // input and result queue depths, powers of two
  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_SUB = 8'h1A;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic CMD_START = 1'b0;

  localparam logic REG_ACCEPT = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam logic       ACCEPT_RST = 1'b1;
  localparam logic [3:0] LIMIT_RST  = 4'd6;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HAND, PH_NUM, PH_COMP, PH_DATA, PH_CRCH, PH_CRCL, PH_HEAD
  } phase_t;

  typedef enum logic [2:0] {
    CL_START, CL_SOH, CL_EOT, CL_CAN, CL_SUB, CL_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    KIND_TX, KIND_DATA, KIND_STATUS
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUNNING, ST_EOT, ST_CAN, ST_HS_FAIL
  } status_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       good;
    logic       pkt_end;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic       accept;
    logic [3:0] limit;
  } cfg_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/xcr_front.sv =====
module xcr_front
  import xcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_take
);

  item_t             mem_r [IQ_DEPTH];
  logic [IQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [IQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [IQ_CW-1:0]  cnt_r, cnt_nxt;
  item_t             cls_item;
  logic              wr_en, rd_en;

  // classify the incoming transaction
  always_comb begin
    cls_item.data = in_rx_byte;
    if (in_cmd == CMD_START) begin
      cls_item.cls = CL_START;
    end else begin
      priority case (in_rx_byte)
        CH_SOH:  cls_item.cls = CL_SOH;
        CH_EOT:  cls_item.cls = CL_EOT;
        CH_CAN:  cls_item.cls = CL_CAN;
        CH_SUB:  cls_item.cls = CL_SUB;
        default: cls_item.cls = CL_OTHER;
      endcase
    end
  end

  assign full       = (cnt_r == IQ_CW'(IQ_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = mem_r[rd_ptr_r];
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

// ===== hw/rtl/xcr_back.sv =====
`include "assert_macros.svh"

module xcr_back
  import xcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       item_valid,
  input  item_t      item,
  output logic       item_take,
  output logic       empty,
  input  logic       pop,
  output result_t    res_out
);

  phase_t            phase_r, phase_nxt;
  logic [3:0]        tries_r, tries_nxt;
  logic [7:0]        blk_num_r, blk_num_nxt;
  logic [7:0]        blk_comp_r, blk_comp_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        crc_hi_r, crc_hi_nxt;
  logic              emit;
  result_t           res;
  logic [7:0]        hs_char;
  logic              good;

  result_t           oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_wr_r, oq_rd_r;
  logic [OQ_CW-1:0]  oq_cnt_r, oq_cnt_nxt;
  logic              oq_full, oq_rd_en;

  assign oq_full   = (oq_cnt_r == OQ_CW'(OQ_DEPTH));
  assign item_take = item_valid && !oq_full;
  assign hs_char   = cfg.accept ? CH_C : CH_NAK;
  assign good      = (blk_comp_r == ~blk_num_r) && (crc_r == {crc_hi_r, item.data});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tries_r <= '0;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      tries_r <= tries_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_num_r  <= blk_num_nxt;
    blk_comp_r <= blk_comp_nxt;
    crc_r      <= crc_nxt;
    crc_hi_r   <= crc_hi_nxt;
  end

  always_comb begin
    phase_nxt    = phase_r;
    tries_nxt    = tries_r;
    blk_num_nxt  = blk_num_r;
    blk_comp_nxt = blk_comp_r;
    idx_nxt      = idx_r;
    crc_nxt      = crc_r;
    crc_hi_nxt   = crc_hi_r;
    emit         = 1'b0;
    res          = '{kind: KIND_TX, data: '0, good: 1'b0, pkt_end: 1'b0,
                     status: ST_RUNNING};
    if (item_take) begin
      if (item.cls == CL_START) begin
        // start restarts the session from any phase
        phase_nxt = PH_HAND;
        tries_nxt = 4'd1;
        emit      = 1'b1;
        res.data  = hs_char;
      end else begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_HAND: begin
            if (item.cls == CL_SOH) begin
              phase_nxt = PH_NUM;
            end else if (tries_r < cfg.limit) begin
              tries_nxt = tries_r + 1'b1;
              emit      = 1'b1;
              res.data  = hs_char;
            end else begin
              phase_nxt  = PH_IDLE;
              emit       = 1'b1;
              res.kind   = KIND_STATUS;
              res.status = ST_HS_FAIL;
            end
          end
          PH_NUM: begin
            blk_num_nxt = item.data;
            phase_nxt   = PH_COMP;
          end
          PH_COMP: begin
            blk_comp_nxt = item.data;
            idx_nxt      = '0;
            crc_nxt      = '0;
            phase_nxt    = PH_DATA;
          end
          PH_DATA: begin
            crc_nxt = crc16_byte(crc_r, item.data);
            idx_nxt = idx_r + 1'b1;
            if (idx_r == IDX_W'(PAYLOAD_BYTES - 1)) begin
              phase_nxt = PH_CRCH;
            end
            if (item.cls != CL_SUB) begin
              emit     = 1'b1;
              res.kind = KIND_DATA;
              res.data = item.data;
            end
          end
          PH_CRCH: begin
            crc_hi_nxt = item.data;
            phase_nxt  = PH_CRCL;
          end
          PH_CRCL: begin
            phase_nxt   = PH_HEAD;
            emit        = 1'b1;
            res.data    = good ? CH_ACK : CH_NAK;
            res.good    = good;
            res.pkt_end = 1'b1;
          end
          PH_HEAD: begin
            priority case (item.cls)
              CL_SOH: phase_nxt = PH_NUM;
              CL_EOT, CL_CAN: begin
                phase_nxt  = PH_IDLE;
                emit       = 1'b1;
                res.data   = CH_ACK;
                res.status = (item.cls == CL_EOT) ? ST_EOT : ST_CAN;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  // result queue
  assign empty    = (oq_cnt_r == '0);
  assign res_out  = oq_r[oq_rd_r];
  assign oq_rd_en = pop && !empty;

  always_comb begin
    unique case ({emit, oq_rd_en})
      2'b10:   oq_cnt_nxt = oq_cnt_r + 1'b1;
      2'b01:   oq_cnt_nxt = oq_cnt_r - 1'b1;
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (emit) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_rd_en) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  `ASSERT_ALWAYS(a_oq_bound, oq_cnt_r <= OQ_CW'(OQ_DEPTH), "result queue overflow")
  `ASSERT_IMPLIES(a_data_phase, emit && res.kind == KIND_DATA && item.cls != CL_START, phase_r == PH_DATA, "payload out of data phase")
  `ASSERT_IMPLIES(a_verdict_phase, emit && res.pkt_end, phase_r == PH_CRCL, "verdict out of CRC phase")
  `ASSERT_IMPLIES(a_good_end, !empty && res_out.good, res_out.pkt_end, "good flag without verdict")

endmodule

// ===== hw/rtl/xmodem_crc_receiver_top.sv =====
// XMODEM-CRC receiver. Push one item per transaction: cmd 0 starts a session
// (sends 'C', or NAK when accept_transfer is 0), cmd 1 delivers one byte
// received from the sender. Results leave through a queue-style port: bytes
// to transmit, tentative payload bytes (0x1A fill dropped), a per-packet
// ACK/NAK verdict telling whether to keep the packet's bytes, and session
// end status. Throughput is one item per clock while the result queue has
// room. An accepted item waits in the input queue until the engine takes
// it, and its result, if any, is registered into the result queue. The
// engine sets the rate and folds a whole byte into the CRC-16 each cycle.
// A four-entry input queue and a four-entry result queue let a stall on one
// side hold up the other only once full. Write configuration only while idle.
module xmodem_crc_receiver_top
  import xcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input transactions
  input  logic       push,
  output logic       full,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  // result transactions
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_packet_good,
  output logic       out_packet_end,
  output logic [1:0] out_session_status,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  cfg_t    cfg_r;
  logic    item_valid, item_take;
  item_t   item;
  result_t res;

  // registers are always writable; the user is to write them only between sessions, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accept <= ACCEPT_RST;
      cfg_r.limit  <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACCEPT: cfg_r.accept <= cfg_data[0];
        REG_LIMIT:  cfg_r.limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: classify and queue incoming transactions
  xcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // back: protocol engine, CRC and result queue
  xcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .empty      (empty),
    .pop        (pop),
    .res_out    (res)
  );

  assign out_kind           = res.kind;
  assign out_byte           = res.data;
  assign out_packet_good    = res.good;
  assign out_packet_end     = res.pkt_end;
  assign out_session_status = res.status;

endmodule

// ===== test/xcr_checker.sv =====
package xcr_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import xcr_pkg::*;

  // CRC-16/XMODEM folded one input bit at a time, MSB first
  function automatic logic [15:0] crc_fold(logic [15:0] acc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

endpackage

module xcr_checker
  import xcr_pkg::*, xcr_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_byte,
  input  logic       out_packet_good,
  input  logic       out_packet_end,
  input  logic [1:0] out_session_status,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  output int         errors,
  output int         waiting,
  output int         results_seen,
  output int         pkts_kept,
  output int         pkts_dropped,
  output int         sessions_closed,
  output int         handshake_fails
);
  timeunit 1ns;
  timeprecision 1ps;

  // receiver state as the block should hold it
  phase_t      rx_phase = PH_IDLE;
  logic [3:0]  hs_tries = '0;
  logic [7:0]  blk_num = '0;
  logic [7:0]  blk_cmp = '0;
  logic [7:0]  crc_hi = '0;
  int unsigned data_cnt = 0;
  logic [15:0] crc_acc = '0;
  logic        accept_q = ACCEPT_RST;
  logic [3:0]  limit_q = LIMIT_RST;

  result_t expected_q[$];

  int err_cnt = 0;
  int seen_cnt = 0;
  int kept_cnt = 0;
  int dropped_cnt = 0;
  int closed_cnt = 0;
  int hsfail_cnt = 0;

  function automatic result_t make_result(kind_t k, logic [7:0] d, logic g, logic e,
                                          status_t s);
    result_t r;
    r.kind    = k;
    r.data    = d;
    r.good    = g;
    r.pkt_end = e;
    r.status  = s;
    return r;
  endfunction

  function automatic logic [7:0] hs_char();
    return accept_q ? CH_C : CH_NAK;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < 50) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %02h, expected %02h (result %0d)",
                                name, got, want, seen_cnt));
    end
  endtask

  task automatic rx_predict(logic cmd, logic [7:0] b);
    logic good;
    if (cmd == CMD_START) begin
      hs_tries = 4'd1;
      rx_phase = PH_HAND;
      expected_q.push_back(make_result(KIND_TX, hs_char(), 1'b0, 1'b0, ST_RUNNING));
    end else begin
      case (rx_phase)
        PH_HAND: begin
          if (b == CH_SOH) begin
            rx_phase = PH_NUM;
          end else if (hs_tries < limit_q) begin
            hs_tries++;
            expected_q.push_back(make_result(KIND_TX, hs_char(), 1'b0, 1'b0, ST_RUNNING));
          end else begin
            rx_phase = PH_IDLE;
            hsfail_cnt++;
            expected_q.push_back(make_result(KIND_STATUS, 8'h00, 1'b0, 1'b0, ST_HS_FAIL));
          end
        end
        PH_NUM: begin
          blk_num  = b;
          rx_phase = PH_COMP;
        end
        PH_COMP: begin
          blk_cmp  = b;
          data_cnt = 0;
          crc_acc  = '0;
          rx_phase = PH_DATA;
        end
        PH_DATA: begin
          crc_acc = crc_fold(crc_acc, b);
          data_cnt++;
          if (data_cnt >= PAYLOAD_BYTES) rx_phase = PH_CRCH;
          // fill bytes are dropped silently
          if (b != CH_SUB) begin
            expected_q.push_back(make_result(KIND_DATA, b, 1'b0, 1'b0, ST_RUNNING));
          end
        end
        PH_CRCH: begin
          crc_hi   = b;
          rx_phase = PH_CRCL;
        end
        PH_CRCL: begin
          good     = (blk_cmp == ~blk_num) && (crc_acc == {crc_hi, b});
          rx_phase = PH_HEAD;
          if (good) kept_cnt++;
          else dropped_cnt++;
          expected_q.push_back(make_result(KIND_TX, good ? CH_ACK : CH_NAK, good, 1'b1,
                                           ST_RUNNING));
        end
        PH_HEAD: begin
          if (b == CH_SOH) begin
            rx_phase = PH_NUM;
          end else if (b == CH_EOT || b == CH_CAN) begin
            rx_phase = PH_IDLE;
            closed_cnt++;
            expected_q.push_back(make_result(KIND_TX, CH_ACK, 1'b0, 1'b0,
                                             (b == CH_EOT) ? ST_EOT : ST_CAN));
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h status %0d",
                                out_kind, out_byte, out_session_status));
    end else begin
      want = expected_q.pop_front();
      check_field("kind", out_kind, want.kind);
      check_field("byte", out_byte, want.data);
      check_field("packet_good", out_packet_good, want.good);
      check_field("packet_end", out_packet_end, want.pkt_end);
      check_field("session_status", out_session_status, want.status);
    end
    seen_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase = PH_IDLE;
      hs_tries = '0;
      blk_num  = '0;
      blk_cmp  = '0;
      crc_hi   = '0;
      data_cnt = 0;
      crc_acc  = '0;
      accept_q = ACCEPT_RST;
      limit_q  = LIMIT_RST;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ACCEPT) accept_q = cfg_data[0];
        else limit_q = cfg_data;
      end
      if (pop && !empty) check_result();
      if (push && !full) rx_predict(in_cmd, in_rx_byte);
    end
    errors          <= err_cnt;
    waiting         <= expected_q.size();
    results_seen    <= seen_cnt;
    pkts_kept       <= kept_cnt;
    pkts_dropped    <= dropped_cnt;
    sessions_closed <= closed_cnt;
    handshake_fails <= hsfail_cnt;
  end

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xcr_pkg::*;
  import xcr_tb_pkg::*;

  // Limit for the slowest legal run: over 1150 items, each paying the worst
  // sender gap plus the worst receiver stall, plus drains.
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int          RANDOM_ITEMS = 1150;
  // input queue depth plus engine and result latency, with margin
  localparam int          DRAIN_CYCLES = 12;
  localparam logic        CMD_BYTE     = ~CMD_START;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       in_cmd = 1'b0;
  logic [7:0] in_rx_byte = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_packet_good;
  logic       out_packet_end;
  logic [1:0] out_session_status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [3:0] cfg_data = '0;

  int errors, waiting, results_seen;
  int pkts_kept, pkts_dropped, sessions_closed, handshake_fails;

  // stimulus bookkeeping
  int          items_sent = 0;
  int          ignored_sent = 0;
  int          burst_left = 0;
  int          cfg_writes = 0;
  int unsigned cycle_count = 0;
  logic [3:0]  cur_limit = LIMIT_RST;
  bit          session_open = 0;

  xmodem_crc_receiver_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_cmd             (in_cmd),
    .in_rx_byte         (in_rx_byte),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_byte           (out_byte),
    .out_packet_good    (out_packet_good),
    .out_packet_end     (out_packet_end),
    .out_session_status (out_session_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Scoreboard sits beside the DUT and sees every transaction on all three
  // channels; we only generate traffic here and read back its counters.
  xcr_checker i_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_cmd             (in_cmd),
    .in_rx_byte         (in_rx_byte),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_byte           (out_byte),
    .out_packet_good    (out_packet_good),
    .out_packet_end     (out_packet_end),
    .out_session_status (out_session_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .errors             (errors),
    .waiting            (waiting),
    .results_seen       (results_seen),
    .pkts_kept          (pkts_kept),
    .pkts_dropped       (pkts_dropped),
    .sessions_closed    (sessions_closed),
    .handshake_fails    (handshake_fails)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side backpressure. The mode is redrawn at random intervals:
  // free-running pop, coin-flip pop, mostly-on with long stalls, mostly-off.
  // pop gets exactly one NBA per edge.
  int pop_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      pop_mode  <= $urandom_range(0, 3);
      mode_left <= $urandom_range(64, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: begin
          pop <= 1'b1;
          if ($urandom_range(0, 31) == 0) hold_left <= $urandom_range(4, 24);
        end
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic int next_burst();
    // mostly short bursts, now and then a long gap-free stretch
    return ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
  endfunction

  // One input transaction. push stays high into the next call unless the
  // burst runs out, so back-to-back items never see push dropped and re-raised.
  task automatic push_item(logic c, logic [7:0] b);
    in_cmd     <= c;
    in_rx_byte <= b;
    push       <= 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      push <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8))
        @(posedge clk);
      burst_left = next_burst();
    end
  endtask

  // Hold the sender off until the scoreboard has nothing outstanding, then give
  // items that produce no result time to drain out of the input queue.
  // waiting is registered and lags the scoreboard, hence the do-while.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = next_burst();
  endtask

  // Leaves cfg_valid high; set_config drops it after the last write.
  task automatic write_reg(logic idx, logic [3:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  // Only called with the receiver idle.
  task automatic set_config(logic acc, logic [3:0] lim);
    settle();
    write_reg(REG_ACCEPT, {3'($urandom), acc});  // upper bits are don't-care
    write_reg(REG_LIMIT, lim);
    cfg_valid  <= 1'b0;
    cur_limit  = lim;
  endtask

  // anything but SOH; EOT and CAN are just noise during the handshake
  function automatic logic [7:0] handshake_noise();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: b = CH_EOT;
      1: b = CH_CAN;
      default: do b = 8'($urandom); while (b == CH_SOH);
    endcase
    return b;
  endfunction

  // line garbage between packets that must be skipped
  function automatic logic [7:0] header_noise();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_SOH || b == CH_EOT || b == CH_CAN);
    return b;
  endfunction

  // Block number, complement, payload, CRC. Occasionally a broken complement
  // or CRC, and occasionally cut short (the next start then hits a busy block).
  task automatic send_packet(output bit aborted);
    logic [7:0]  num, cmp, d;
    logic [15:0] crc;
    int          cut, sub_pct;
    bit          bad_crc;
    num     = 8'($urandom);
    cmp     = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ~num;
    cut     = ($urandom_range(0, 11) == 0) ? $urandom_range(0, PAYLOAD_BYTES + 3)
                                           : PAYLOAD_BYTES + 4;
    sub_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : 3;
    bad_crc = ($urandom_range(0, 6) == 0);
    crc     = '0;
    aborted = 0;
    for (int i = 0; i < PAYLOAD_BYTES + 4; i++) begin
      if (i == cut) aborted = 1;
      if (!aborted) begin
        if (i == 0) begin
          d = num;
        end else if (i == 1) begin
          d = cmp;
        end else if (i < PAYLOAD_BYTES + 2) begin
          d   = ($urandom_range(0, 99) < sub_pct) ? CH_SUB : 8'($urandom);
          crc = crc_fold(crc, d);
        end else if (i == PAYLOAD_BYTES + 2) begin
          if (bad_crc) crc ^= 16'(1) << $urandom_range(0, 15);
          d = crc[15:8];
        end else begin
          d = crc[7:0];
        end
        push_item(CMD_BYTE, d);
      end
    end
  endtask

  // One receive session: start, some handshake retries, then either a
  // handshake timeout or 1..3 packets closed by EOT/CAN (sometimes left open).
  task automatic run_session();
    int eff;
    int npk;
    bit aborted;
    push_item(CMD_START, 8'($urandom));
    session_open = 1;
    eff = (cur_limit == 0) ? 1 : int'(cur_limit);
    if ($urandom_range(0, 4) == 0) begin
      // the last of these exhausts the retries
      repeat (eff) push_item(CMD_BYTE, handshake_noise());
      session_open = 0;
    end else begin
      repeat ($urandom_range(0, eff - 1)) push_item(CMD_BYTE, handshake_noise());
      push_item(CMD_BYTE, CH_SOH);
      npk     = $urandom_range(1, 3);
      aborted = 0;
      for (int p = 0; p < npk && !aborted; p++) begin
        if (p != 0) push_item(CMD_BYTE, CH_SOH);
        send_packet(aborted);
        if (!aborted && $urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) push_item(CMD_BYTE, header_noise());
        end
      end
      if (!aborted && $urandom_range(0, 9) != 0) begin
        push_item(CMD_BYTE, $urandom_range(0, 1) ? CH_EOT : CH_CAN);
        session_open = 0;
      end
    end
  endtask

  initial begin
    int base;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = next_burst();

    // --- directed: reset config (accept, limit 6) ---
    // bytes on an idle receiver are dropped
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'h00);
    // start, then start again while busy
    push_item(CMD_START, 8'hA5);
    push_item(CMD_START, 8'hFF);
    // SOH and a block number, then a restart in the middle of the header
    push_item(CMD_BYTE, CH_SOH);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_START, 8'h00);
    // retries up to the limit; EOT/CAN count as plain noise here
    push_item(CMD_BYTE, CH_EOT);
    push_item(CMD_BYTE, CH_CAN);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, CH_ACK);
    // one past the limit: handshake failure, back to idle
    push_item(CMD_BYTE, 8'h80);
    // SOH to an idle receiver is ignored
    push_item(CMD_BYTE, CH_SOH);

    // refuse transfers, limit zero acts as one (pause doubles as pressure)
    set_config(1'b0, 4'd0);
    push_item(CMD_START, 8'hFF);
    push_item(CMD_BYTE, 8'h7F);

    // widest retry window
    set_config(1'b1, 4'd15);
    push_item(CMD_START, 8'h3C);
    session_open = 1;

    // --- random sessions ---
    base = items_sent - ignored_sent;
    while (items_sent - ignored_sent - base < RANDOM_ITEMS) begin
      if (!session_open) begin
        if ($urandom_range(0, 1) == 0) begin
          set_config(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        end else if ($urandom_range(0, 3) == 0) begin
          settle();
        end
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            push_item(CMD_BYTE, 8'($urandom));
            ignored_sent++;
          end
        end
      end
      run_session();
    end

    settle();
    $display("covered %0d input items (%0d to an idle receiver), %0d results, %0d reg writes",
             items_sent, ignored_sent, results_seen, cfg_writes);
    $display("packets kept %0d / discarded %0d, sessions closed %0d, handshake timeouts %0d",
             pkts_kept, pkts_dropped, sessions_closed, handshake_fails);
    if (errors == 0 && waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
